FILE: design/mbe_pkg.sv
// Shared types and constants of the mask boundary edge extractor.
package mbe_pkg;

  // Width of a grid corner coordinate on the result channel.
  localparam int COORD_W = 13;
  // Width of a configuration register value.
  localparam int DIM_W = 13;
  // Width of the configuration register index.
  localparam int CFG_IDX_W = 4;
  // Image size after reset, before any register write.
  localparam int DIM_RESET = 4096;

  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_IMAGE_WIDTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_IMAGE_HEIGHT = cfg_idx_t'(1);

  // Edge kinds, in the order they leave the block for one pixel.
  localparam int EDGE_ROW    = 0;  // Edge shared with the cell above.
  localparam int EDGE_RIGHT  = 1;  // Right image border.
  localparam int EDGE_BOTTOM = 2;  // Bottom image border.
  localparam int EDGE_COL    = 3;  // Edge shared with the cell to the left.
  localparam int EDGE_KINDS  = 4;

  typedef logic [EDGE_KINDS-1:0] edge_set_t;

  // One pixel on its way from the row-memory stage to the edge stage.
  typedef struct packed {
    logic   mask_bit;    // Bit of this pixel.
    logic   above_known; // Row above lies inside the image.
    logic   left_bit;    // Bit of the left neighbor, zero at the first column.
    logic   last_col;
    logic   last_row;
    coord_t x;
    coord_t y;
  } pix_t;

endpackage

FILE: design/mbe_if.sv
// Channel interfaces of the mask boundary edge extractor.
interface mbe_in_if;
  logic valid;
  logic ready;
  logic mask_bit;
  modport source (output valid, output mask_bit, input ready);
  modport sink (input valid, input mask_bit, output ready);
endinterface

interface mbe_out_if;
  logic           valid;
  logic           ready;
  mbe_pkg::coord_t start_x;
  mbe_pkg::coord_t start_y;
  mbe_pkg::coord_t end_x;
  mbe_pkg::coord_t end_y;
  logic           last_of_pixel;
  logic           frame_done;
  modport source (output valid, output start_x, output start_y, output end_x, output end_y,
                  output last_of_pixel, output frame_done, input ready);
  modport sink (input valid, input start_x, input start_y, input end_x, input end_y,
                input last_of_pixel, input frame_done, output ready);
endinterface

interface mbe_cfg_if;
  logic              valid;
  logic              ready;
  mbe_pkg::cfg_idx_t index;
  mbe_pkg::dim_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/mask_boundary_edge_extract.sv
// Top level of the mask boundary edge extractor.
// Throughput: one pixel per cycle when it causes at most one edge and the output is ready;
// otherwise the single result register, which gives one edge per cycle while the output is
// ready, sets the pace, and a pixel may cause an edge of every kind.
// Reset clears position, left neighbor and pipeline; both sizes return to 4096, capped at the max.
// The row memory is not cleared; the first row of a frame ignores what it reads.
module mask_boundary_edge_extract #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input logic        clk,
  input logic        rst_n,
  mbe_in_if.sink     in_ch,
  mbe_out_if.source  out_ch,
  mbe_cfg_if.sink    cfg_ch
);

  localparam int XW = $clog2(MAX_WIDTH);

  logic          pix_valid;
  mbe_pkg::pix_t pix;
  logic          pix_take;
  logic          ram_en;
  logic [XW-1:0] ram_addr;
  logic          ram_wr_data;
  logic          ram_rd_data;

  // Position tracking and row memory addressing.
  mbe_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_ch      (cfg_ch),
    .pix_take    (pix_take),
    .pix_valid   (pix_valid),
    .pix         (pix),
    .ram_en      (ram_en),
    .ram_addr    (ram_addr),
    .ram_wr_data (ram_wr_data)
  );

  // Mask bits of the previous row.
  mbe_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (ram_en),
    .wr_addr (ram_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_en),
    .rd_addr (ram_addr),
    .rd_data (ram_rd_data)
  );

  // Edge generation and result serializer.
  mbe_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix       (pix),
    .above_rd  (ram_rd_data),
    .pix_take  (pix_take),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // An accepted pixel is in the edge-evaluation stage on the next cycle.
  a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> pix_valid)
    else $error("accepted pixel did not reach the edge stage");

  // A pixel waiting for the edge stage keeps its record and its memory read data.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_valid && !pix_take) |=> ($stable(pix) && $stable(ram_rd_data)))
    else $error("waiting pixel changed");

  // Every edge is axis aligned: its ends differ along exactly one axis.
  a_unit_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.start_x == out_ch.end_x) != (out_ch.start_y == out_ch.end_y)))
    else $error("edge is not axis aligned");
`endif

endmodule

FILE: design/mbe_ram.sv
// Generic synchronous RAM, one write and one read port, registered read-first output.
module mbe_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old content.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

FILE: design/mbe_ctrl.sv
// Raster position tracking, configuration registers and row memory access.
module mbe_ctrl #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  mbe_in_if.sink                       in_ch,
  mbe_cfg_if.sink                      cfg_ch,
  input  logic                         pix_take,
  output logic                         pix_valid,
  output mbe_pkg::pix_t                pix,
  output logic                         ram_en,
  output logic [$clog2(MAX_WIDTH)-1:0] ram_addr,
  output logic                         ram_wr_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int RESET_W = (MAX_WIDTH < mbe_pkg::DIM_RESET) ? MAX_WIDTH : mbe_pkg::DIM_RESET;
  localparam int RESET_H = (MAX_HEIGHT < mbe_pkg::DIM_RESET) ? MAX_HEIGHT : mbe_pkg::DIM_RESET;
  localparam logic [XW-1:0] W_LAST_MAX   = XW'(MAX_WIDTH - 1);
  localparam logic [YW-1:0] H_LAST_MAX   = YW'(MAX_HEIGHT - 1);
  localparam logic [XW-1:0] W_LAST_RESET = XW'(RESET_W - 1);
  localparam logic [YW-1:0] H_LAST_RESET = YW'(RESET_H - 1);

  logic [XW-1:0] w_last_r, w_last_nxt;
  logic [YW-1:0] h_last_r, h_last_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic          left_r, left_nxt;
  logic          pix_valid_r, pix_valid_nxt;
  mbe_pkg::pix_t pix_r;
  logic          accept;
  logic          cfg_write;
  logic          last_col;
  logic          last_row;

  assign cfg_ch.ready = 1'b1;
  assign cfg_write    = cfg_ch.valid && (cfg_ch.index == mbe_pkg::REG_IMAGE_WIDTH ||
                                         cfg_ch.index == mbe_pkg::REG_IMAGE_HEIGHT);

  // The stage can take a pixel when it is empty or its pixel moves on this cycle.
  assign in_ch.ready = !pix_valid_r || pix_take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign last_col    = (x_r == w_last_r);
  assign last_row    = (y_r == h_last_r);

  // The row memory is read and written at the pixel's column in the same cycle.
  assign ram_en      = accept;
  assign ram_addr    = x_r;
  assign ram_wr_data = in_ch.mask_bit;

  assign pix_valid = pix_valid_r;
  assign pix       = pix_r;

  // Clamped last column and last row from register writes.
  always_comb begin
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        mbe_pkg::REG_IMAGE_WIDTH: begin
          if (cfg_ch.data == '0) begin
            w_last_nxt = '0;
          end else if (int'(cfg_ch.data) > MAX_WIDTH) begin
            w_last_nxt = W_LAST_MAX;
          end else begin
            w_last_nxt = XW'(cfg_ch.data - mbe_pkg::dim_t'(1));
          end
        end
        mbe_pkg::REG_IMAGE_HEIGHT: begin
          if (cfg_ch.data == '0) begin
            h_last_nxt = '0;
          end else if (int'(cfg_ch.data) > MAX_HEIGHT) begin
            h_last_nxt = H_LAST_MAX;
          end else begin
            h_last_nxt = YW'(cfg_ch.data - mbe_pkg::dim_t'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Raster position and left neighbor; a register write restarts the frame.
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    left_nxt = left_r;
    priority if (cfg_write) begin
      x_nxt    = '0;
      y_nxt    = '0;
      left_nxt = 1'b0;
    end else if (accept) begin
      if (last_col) begin
        x_nxt    = '0;
        left_nxt = 1'b0;
        y_nxt    = last_row ? '0 : y_r + YW'(1);
      end else begin
        x_nxt    = x_r + XW'(1);
        left_nxt = in_ch.mask_bit;
      end
    end
  end

  assign pix_valid_nxt = accept ? 1'b1 : (pix_take ? 1'b0 : pix_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r    <= W_LAST_RESET;
      h_last_r    <= H_LAST_RESET;
      x_r         <= '0;
      y_r         <= '0;
      left_r      <= 1'b0;
      pix_valid_r <= 1'b0;
    end else begin
      w_last_r    <= w_last_nxt;
      h_last_r    <= h_last_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      left_r      <= left_nxt;
      pix_valid_r <= pix_valid_nxt;
    end
  end

  // Pixel record; the above bit arrives from the row memory read, registered alongside it.
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r.mask_bit    <= in_ch.mask_bit;
      pix_r.above_known <= (y_r != '0);
      pix_r.left_bit    <= left_r && (x_r != '0);
      pix_r.last_col    <= last_col;
      pix_r.last_row    <= last_row;
      pix_r.x           <= mbe_pkg::coord_t'(x_r);
      pix_r.y           <= mbe_pkg::coord_t'(y_r);
    end
  end

endmodule

FILE: design/mbe_emit.sv
// Edge set evaluation and one-edge-per-cycle result serializer, while the result channel is ready.
module mbe_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pix_valid,
  input  mbe_pkg::pix_t pix,
  input  logic          above_rd,
  output logic          pix_take,
  mbe_out_if.source     out_ch
);

  mbe_pkg::edge_set_t pend_r, pend_nxt;
  mbe_pkg::edge_set_t new_set;
  mbe_pkg::edge_set_t sel;
  mbe_pkg::coord_t    x_r, y_r;
  logic               fg_r;
  logic               frame_end_r;
  mbe_pkg::coord_t    x1, y1;
  logic               above;
  logic               out_valid_r;
  logic               out_load;
  logic               emit;
  logic               sel_last;
  logic               busy;

  // Edges of the pixel: each boundary side where the bits on both sides differ.
  assign above = pix.above_known && above_rd;
  always_comb begin
    new_set = '0;
    new_set[mbe_pkg::EDGE_ROW]    = pix.mask_bit ^ above;
    new_set[mbe_pkg::EDGE_RIGHT]  = pix.mask_bit && pix.last_col;
    new_set[mbe_pkg::EDGE_BOTTOM] = pix.mask_bit && pix.last_row;
    new_set[mbe_pkg::EDGE_COL]    = pix.mask_bit ^ pix.left_bit;
  end

  // Lowest pending edge goes out first.
  assign sel      = pend_r & (~pend_r + mbe_pkg::edge_set_t'(1));
  assign sel_last = ((pend_r & ~sel) == '0);
  assign busy     = (pend_r != '0);
  assign out_load = !out_valid_r || out_ch.ready;
  assign emit     = busy && out_load;
  assign pix_take = pix_valid && (!busy || (emit && sel_last));

  always_comb begin
    pend_nxt = pend_r;
    if (pix_take) begin
      pend_nxt = new_set;
    end else if (emit) begin
      pend_nxt = pend_r & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (out_load) begin
        out_valid_r <= emit;
      end
    end
  end

  // Pixel coordinates held while its edges drain.
  always_ff @(posedge clk) begin
    if (pix_take) begin
      x_r         <= pix.x;
      y_r         <= pix.y;
      fg_r        <= pix.mask_bit;
      frame_end_r <= pix.last_col && pix.last_row;
    end
  end

  assign x1 = x_r + mbe_pkg::coord_t'(1);
  assign y1 = y_r + mbe_pkg::coord_t'(1);

  // Corner coordinates of the selected edge, clockwise around the foreground.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.last_of_pixel <= sel_last;
      out_ch.frame_done    <= frame_end_r;
      unique case (1'b1)
        sel[mbe_pkg::EDGE_ROW]: begin
          out_ch.start_x <= fg_r ? x_r : x1;
          out_ch.start_y <= y_r;
          out_ch.end_x   <= fg_r ? x1 : x_r;
          out_ch.end_y   <= y_r;
        end
        sel[mbe_pkg::EDGE_RIGHT]: begin
          out_ch.start_x <= x1;
          out_ch.start_y <= y_r;
          out_ch.end_x   <= x1;
          out_ch.end_y   <= y1;
        end
        sel[mbe_pkg::EDGE_BOTTOM]: begin
          out_ch.start_x <= x1;
          out_ch.start_y <= y1;
          out_ch.end_x   <= x_r;
          out_ch.end_y   <= y1;
        end
        default: begin
          out_ch.start_x <= x_r;
          out_ch.start_y <= fg_r ? y1 : y_r;
          out_ch.end_x   <= x_r;
          out_ch.end_y   <= fg_r ? y_r : y1;
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

FILE: bench/mask_boundary_edge_extract_tb.sv
// Self-checking testbench for the mask boundary edge extractor.
`timescale 1ns / 100ps

module mask_boundary_edge_extract_tb;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;
  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Cycles allowed after the last expected edge for pixels that cause none.
  localparam int DRAIN_CYCLES = 10;
  // Register index that the block does not implement.
  localparam mbe_pkg::cfg_idx_t REG_UNUSED = '1;

  typedef struct packed {
    mbe_pkg::coord_t start_x;
    mbe_pkg::coord_t start_y;
    mbe_pkg::coord_t end_x;
    mbe_pkg::coord_t end_y;
    logic            last_of_pixel;
    logic            frame_done;
  } edge_t;

  typedef enum {STYLE_NOISE, STYLE_BLOBS, STYLE_SOLID, STYLE_EMPTY} pix_style_t;

  // Predicts the boundary edges of each accepted pixel and checks the block's edges.
  class edge_ledger;
    bit          row_bits [MAX_W];
    bit          left_q;
    int unsigned col_q;
    int unsigned row_q;
    int unsigned width_reg;
    int unsigned height_reg;
    edge_t       pending_edges [$];
    int unsigned errors;
    int unsigned pixels;
    int unsigned edges;
    int unsigned writes;

    function new();
      width_reg  = mbe_pkg::DIM_RESET;
      height_reg = mbe_pkg::DIM_RESET;
    endfunction

    static function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function int unsigned eff_width();
      return clamp_dim(width_reg, MAX_W);
    endfunction

    function int unsigned eff_height();
      return clamp_dim(height_reg, MAX_H);
    endfunction

    static function edge_t make_edge(int unsigned sx, int unsigned sy,
                                     int unsigned ex, int unsigned ey);
      edge_t e;
      e.start_x       = mbe_pkg::coord_t'(sx);
      e.start_y       = mbe_pkg::coord_t'(sy);
      e.end_x         = mbe_pkg::coord_t'(ex);
      e.end_y         = mbe_pkg::coord_t'(ey);
      e.last_of_pixel = 1'b0;
      e.frame_done    = 1'b0;
      return e;
    endfunction

    // A write to a known register restarts the frame; unknown indexes are ignored.
    function void write_reg(mbe_pkg::cfg_idx_t idx, mbe_pkg::dim_t val);
      writes++;
      case (idx)
        mbe_pkg::REG_IMAGE_WIDTH: width_reg = val;
        mbe_pkg::REG_IMAGE_HEIGHT: height_reg = val;
        default: return;
      endcase
      left_q = 1'b0;
      col_q  = 0;
      row_q  = 0;
    endfunction

    // Works out the edges of one accepted pixel in the order the block sends them.
    function void note_pixel(bit c);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned y;
      bit          a;
      bit          l;
      bit          last_col;
      bit          last_row;
      edge_t       batch [$];
      w = eff_width();
      h = eff_height();
      x = (col_q >= w) ? w - 1 : col_q;
      y = (row_q >= h) ? h - 1 : row_q;
      last_col = (x == w - 1);
      last_row = (y == h - 1);
      a = (y == 0) ? 1'b0 : row_bits[x];
      l = (x == 0) ? 1'b0 : left_q;

      // Edge shared with the row above, or the top border on the first row.
      if (c && !a) batch.push_back(make_edge(x, y, x + 1, y));
      else if (a && !c) batch.push_back(make_edge(x + 1, y, x, y));
      // Right and bottom image borders.
      if (c && last_col) batch.push_back(make_edge(x + 1, y, x + 1, y + 1));
      if (c && last_row) batch.push_back(make_edge(x + 1, y + 1, x, y + 1));
      // Edge shared with the left neighbor, or the left border in the first column.
      if (c && !l) batch.push_back(make_edge(x, y + 1, x, y));
      else if (l && !c) batch.push_back(make_edge(x, y, x, y + 1));

      if (batch.size() != 0) batch[batch.size() - 1].last_of_pixel = 1'b1;
      foreach (batch[k]) begin
        batch[k].frame_done = last_col && last_row;
        pending_edges.push_back(batch[k]);
      end

      // Advance the raster position.
      row_bits[x] = c;
      left_q = c;
      if (last_col) begin
        col_q  = 0;
        left_q = 1'b0;
        row_q  = last_row ? 0 : y + 1;
      end else begin
        col_q = x + 1;
      end
      pixels++;
    endfunction

    function void same_field(string name, logic [mbe_pkg::COORD_W-1:0] want,
                             logic [mbe_pkg::COORD_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compares one edge from the block with the oldest predicted edge.
    function void check_edge(edge_t got);
      edge_t want;
      if (pending_edges.size() == 0) begin
        $error("edge (%0d,%0d)->(%0d,%0d) arrived with none expected",
               got.start_x, got.start_y, got.end_x, got.end_y);
        errors++;
        return;
      end
      want = pending_edges.pop_front();
      edges++;
      same_field("start_x", want.start_x, got.start_x);
      same_field("start_y", want.start_y, got.start_y);
      same_field("end_x", want.end_x, got.end_x);
      same_field("end_y", want.end_y, got.end_y);
      same_field("last_of_pixel", want.last_of_pixel, got.last_of_pixel);
      same_field("frame_done", want.frame_done, got.frame_done);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int unsigned stuck_cycles;

  edge_ledger ledger = new();

  mbe_in_if  in_ch ();
  mbe_out_if out_ch ();
  mbe_cfg_if cfg_ch ();

  mask_boundary_edge_extract #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic bit pick_bit(pix_style_t style, bit prev);
    case (style)
      STYLE_NOISE: return $urandom_range(0, 1);
      STYLE_BLOBS: return ($urandom_range(0, 4) == 0) ? !prev : prev;
      STYLE_SOLID: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Picks a register value: mostly small sizes, sometimes zero, the reset size or beyond the maximum.
  function automatic mbe_pkg::dim_t pick_dim(bit is_width);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return mbe_pkg::dim_t'(0);
    if (r == 1) return mbe_pkg::dim_t'($urandom_range(MAX_W + 1, 8191));
    if (r == 2) return mbe_pkg::dim_t'(mbe_pkg::DIM_RESET);
    if (r < 5) begin
      return mbe_pkg::dim_t'(is_width ? $urandom_range(9, 40) : $urandom_range(7, 12));
    end
    return mbe_pkg::dim_t'(is_width ? $urandom_range(1, 8) : $urandom_range(1, 6));
  endfunction

  // Result side: ready toggles at random, held high through calm stretches.
  initial begin
    int unsigned g;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      g = pick_gap();
      if (g != 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat (1 + $urandom_range(0, 12)) @(posedge clk);
    end
  end

  // Edge monitor and hang watchdog.
  always @(posedge clk) begin : monitor
    edge_t seen;
    if (rst_n === 1'b1) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        seen.start_x       = out_ch.start_x;
        seen.start_y       = out_ch.start_y;
        seen.end_x         = out_ch.end_x;
        seen.end_y         = out_ch.end_y;
        seen.last_of_pixel = out_ch.last_of_pixel;
        seen.frame_done    = out_ch.frame_done;
        ledger.check_edge(seen);
      end
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("mask_boundary_edge_extract_tb failed");
        $finish;
      end
    end
  end

  // Offers one pixel after a random gap and waits for its transaction.
  task automatic send_pixel(input bit b);
    int unsigned g;
    g = pick_gap();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mask_bit <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    ledger.note_pixel(b);
  endtask

  // Sends the lowest count bits of a pattern, most significant first.
  task automatic send_pattern(input logic [31:0] pattern, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_pixel(pattern[count - 1 - i]);
  endtask

  task automatic send_run(input int unsigned count, input pix_style_t style, input bit end_high);
    bit b;
    b = $urandom_range(0, 1);
    for (int unsigned i = 0; i < count; i++) begin
      b = pick_bit(style, b);
      if (end_high && i == count - 1) b = 1'b1;
      send_pixel(b);
    end
  endtask

  // Stops offering pixels and lets every predicted edge drain out.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (ledger.pending_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input mbe_pkg::cfg_idx_t idx, input mbe_pkg::dim_t val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    ledger.write_reg(idx, val);
  endtask

  task automatic random_style(output pix_style_t style);
    int unsigned r;
    r = $urandom_range(0, 9);
    style = (r < 4) ? STYLE_NOISE : (r < 8) ? STYLE_BLOBS : (r == 8) ? STYLE_SOLID : STYLE_EMPTY;
  endtask

  initial begin
    int unsigned goal;
    int unsigned frame_px;
    int unsigned pick;
    pix_style_t  style;

    in_ch.valid    <= 1'b0;
    in_ch.mask_bit <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= mbe_pkg::REG_IMAGE_WIDTH;
    cfg_ch.data    <= '0;
    rst_n          <= 1'b0;
    calm = 1'b0;
    stuck_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening pixels at the reset size of 4096 by 4096.
    send_pattern(32'b1101001, 7);
    settle();

    // Small frame that hits every edge kind, then a wrap into a second frame.
    write_reg(mbe_pkg::REG_IMAGE_WIDTH, mbe_pkg::dim_t'(3));
    write_reg(mbe_pkg::REG_IMAGE_HEIGHT, mbe_pkg::dim_t'(2));
    send_pattern(32'b101110, 6);
    send_pattern(32'b010001, 6);
    settle();

    // A write to an unused index must not restart the frame.
    write_reg(mbe_pkg::REG_IMAGE_WIDTH, mbe_pkg::dim_t'(2));
    send_pattern(32'b11, 2);
    settle();
    write_reg(REG_UNUSED, mbe_pkg::dim_t'($urandom));
    send_pattern(32'b01, 2);
    settle();

    // Zero sizes clamp to single-pixel frames.
    write_reg(mbe_pkg::REG_IMAGE_WIDTH, mbe_pkg::dim_t'(0));
    write_reg(mbe_pkg::REG_IMAGE_HEIGHT, mbe_pkg::dim_t'(0));
    send_pattern(32'b101, 3);
    settle();

    // An oversized width clamps to the widest row, so a short run stays in one row.
    calm = 1'b1;
    write_reg(mbe_pkg::REG_IMAGE_WIDTH, mbe_pkg::dim_t'(8191));
    write_reg(mbe_pkg::REG_IMAGE_HEIGHT, mbe_pkg::dim_t'(1));
    send_run(24, STYLE_BLOBS, 1'b1);
    settle();
    calm = 1'b0;
    write_reg(mbe_pkg::REG_IMAGE_WIDTH, mbe_pkg::dim_t'(1));
    write_reg(mbe_pkg::REG_IMAGE_HEIGHT, mbe_pkg::dim_t'(mbe_pkg::DIM_RESET));
    send_run(24, STYLE_BLOBS, 1'b1);
    settle();

    // Random sizes with whole frames, broken frames and stray register writes.
    goal = ledger.pixels + 250;
    while (ledger.pixels < goal) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 3);
      if (pick != 1) write_reg(mbe_pkg::REG_IMAGE_WIDTH, pick_dim(1'b1));
      if (pick != 0) write_reg(mbe_pkg::REG_IMAGE_HEIGHT, pick_dim(1'b0));
      frame_px = ledger.eff_width() * ledger.eff_height();
      if (frame_px > 36) begin
        random_style(style);
        send_run($urandom_range(4, 60), style, 1'b0);
      end else begin
        repeat ($urandom_range(1, 2)) begin
          random_style(style);
          send_run(frame_px, style, 1'b0);
        end
        if ($urandom_range(0, 4) == 0) begin
          random_style(style);
          send_run($urandom_range(1, frame_px), style, 1'b0);
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        settle();
        write_reg(REG_UNUSED, mbe_pkg::dim_t'($urandom));
        send_run($urandom_range(1, 8), STYLE_NOISE, 1'b0);
      end
    end
    calm = 1'b0;
    settle();

    $display("Covered %0d pixels and %0d edges across %0d register writes,",
             ledger.pixels, ledger.edges, ledger.writes);
    $display("from single-pixel frames to sizes clamped at the 4096 maximum.");
    if (ledger.errors == 0) begin
      $display("mask_boundary_edge_extract_tb passed");
    end else begin
      $display("mask_boundary_edge_extract_tb failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/mbe_pkg.sv
design/mbe_if.sv
design/mbe_ram.sv
design/mbe_ctrl.sv
design/mbe_emit.sv
design/mask_boundary_edge_extract.sv
bench/mask_boundary_edge_extract_tb.sv
